// ===== rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the indexed list store: command and status
// codes, controller states and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

  localparam int CmdW    = 3;
  localparam int PosW    = 8;
  localparam int ValW    = 32;
  localparam int StatusW = 2;
  localparam int CntOutW = 9;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 3'd0,
    CMD_SET    = 3'd1,
    CMD_GET    = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_FIND   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_REMOVE,
    S_SHIFT,
    S_FIND
  } fsm_state_e;

  typedef struct packed {
    logic [ValW-1:0]    value_out;
    logic               found;
    logic [PosW-1:0]    found_position;
    logic [StatusW-1:0] status;
    logic [CntOutW-1:0] count_out;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/ils_if.sv =====
// ----------------------------------------------------------------------------
// ils_if
// Valid/ready channels of the indexed list store: the command request
// channel and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ils_cmd_if import ils_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    command;
  logic [PosW-1:0]    position;
  logic [ValW-1:0]    value_in;

  modport source (output valid, command, position, value_in, input ready);
  modport sink   (input valid, command, position, value_in, output ready);
endinterface

interface ils_res_if import ils_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ValW-1:0]    value_out;
  logic               found;
  logic [PosW-1:0]    found_position;
  logic [StatusW-1:0] status;
  logic [CntOutW-1:0] count_out;

  modport source (output valid, value_out, found, found_position, status, count_out,
                  input ready);
  modport sink   (input valid, value_out, found, found_position, status, count_out,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/ils_store.sv =====
// ----------------------------------------------------------------------------
// ils_store
// Entry memory of the list: one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_store #(
  parameter int Depth = 256,
  parameter int Width = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/indexed_list_store_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Ordered list of words kept compactly in an entry memory of CAPACITY words.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one request (command, position, value_in); res_o returns
//   exactly one result per request, in order, with the element count after
//   the command. Both channels are valid/ready.
//   Append, set, clear, unknown codes and range errors are answered
//   without a memory read; get reads the entry once; remove reads the
//   entry, then moves each later entry down one place; find reads the
//   entries in order until a hit or the end of the list, and a find on
//   an empty list is a miss without a read.
//   The memory has one read port, so remove and find walk one entry per
//   cycle. Requests are taken one at a time, only when the controller is
//   idle and the holding slot is empty. A new one is taken while the
//   previous result waits in the output register.
//   Reset empties the list (count zero); memory contents are not cleared.
//   A stalled result holds in the output register and one more result
//   waits in a holding slot; requests stop being taken after that.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store_top import ils_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ils_cmd_if.sink  cmd_i,
  ils_res_if.source res_o
);

  localparam int IdxW  = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int WordW = (DATA_WIDTH < ValW) ? DATA_WIDTH : ValW;
  localparam int CmpW  = (CntW > PosW) ? CntW : PosW;

  fsm_state_e       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic [WordW-1:0] key_q, key_d;
  res_t             res_q, res_d;
  logic             res_valid_q, res_valid_d;
  res_t             out_q;
  logic             out_valid_q;

  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic [IdxW-1:0]  mem_raddr;
  logic [WordW-1:0] mem_rdata;

  logic             accept;
  cmd_e             cmd;
  logic             pos_oob;
  logic [IdxW-1:0]  pos_idx;
  logic [WordW-1:0] word_in;
  logic             full;
  logic             more;
  logic             key_hit;
  logic [CntW-1:0]  rd_prev;
  logic             xfer;

  logic             res_set;
  logic [ValW-1:0]  res_val;
  logic             res_found;
  logic [PosW-1:0]  res_fpos;
  status_e          res_status;

  assign cmd_i.ready = (state_q == S_IDLE) && !res_valid_q;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign cmd         = cmd_e'(cmd_i.command);
  assign pos_oob     = CmpW'(cmd_i.position) >= CmpW'(count_q);
  assign pos_idx     = IdxW'(cmd_i.position);
  assign word_in     = cmd_i.value_in[WordW-1:0];
  assign full        = count_q == CntW'(CAPACITY);
  assign more        = rd_idx_q < count_q;
  assign key_hit     = mem_rdata == key_q;
  assign rd_prev     = rd_idx_q - CntW'(1);

  ils_store #(
    .Depth (CAPACITY),
    .Width (WordW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_GET:    if (!pos_oob) state_d = S_GET;
            CMD_REMOVE: if (!pos_oob) state_d = S_REMOVE;
            CMD_FIND:   if (count_q != '0) state_d = S_FIND;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_GET:    state_d = S_IDLE;
      S_REMOVE: state_d = more ? S_SHIFT : S_IDLE;
      S_SHIFT:  state_d = more ? S_SHIFT : S_IDLE;
      S_FIND:   state_d = (key_hit || !more) ? S_IDLE : S_FIND;
      default:  state_d = S_IDLE;
    endcase
  end

  // memory accesses, counters and result
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = word_in;
    mem_raddr  = '0;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    key_d      = key_q;
    res_set    = 1'b0;
    res_val    = '0;
    res_found  = 1'b0;
    res_fpos   = '0;
    res_status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_APPEND: begin
              res_set = 1'b1;
              if (full) begin
                res_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = IdxW'(count_q);
                count_d   = count_q + CntW'(1);
              end
            end
            CMD_SET: begin
              res_set = 1'b1;
              if (pos_oob) begin
                res_status = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos_idx;
              end
            end
            CMD_GET: begin
              mem_raddr = pos_idx;
              if (pos_oob) begin
                res_set    = 1'b1;
                res_status = ST_RANGE;
              end
            end
            CMD_REMOVE: begin
              mem_raddr = pos_idx;
              rd_idx_d  = CntW'(cmd_i.position) + CntW'(1);
              if (pos_oob) begin
                res_set    = 1'b1;
                res_status = ST_RANGE;
              end
            end
            CMD_FIND: begin
              key_d     = word_in;
              rd_idx_d  = CntW'(1);
              if (count_q == '0) begin
                res_set = 1'b1;
              end
            end
            CMD_CLEAR: begin
              res_set = 1'b1;
              count_d = '0;
            end
            default: begin
              res_set = 1'b1;
            end
          endcase
        end
      end
      S_GET: begin
        res_set = 1'b1;
        res_val = ValW'(mem_rdata);
      end
      S_REMOVE, S_SHIFT: begin
        if (state_q == S_REMOVE) begin
          // removed word, parked in the key register during the shift
          key_d   = mem_rdata;
          res_val = ValW'(mem_rdata);
        end else begin
          // entry read last cycle moves down one place
          mem_we    = 1'b1;
          mem_waddr = IdxW'(rd_idx_q - CntW'(2));
          mem_wdata = mem_rdata;
          res_val   = ValW'(key_q);
        end
        if (more) begin
          mem_raddr = IdxW'(rd_idx_q);
          rd_idx_d  = rd_idx_q + CntW'(1);
        end else begin
          res_set = 1'b1;
          count_d = count_q - CntW'(1);
        end
      end
      S_FIND: begin
        if (key_hit) begin
          res_set   = 1'b1;
          res_found = 1'b1;
          res_fpos  = PosW'(rd_prev);
        end else if (more) begin
          mem_raddr = IdxW'(rd_idx_q);
          rd_idx_d  = rd_idx_q + CntW'(1);
        end else begin
          res_set = 1'b1;
        end
      end
      default: begin
        res_set = 1'b0;
      end
    endcase

    res_d = res_q;
    if (res_set) begin
      res_d.value_out      = res_val;
      res_d.found          = res_found;
      res_d.found_position = res_fpos;
      res_d.status         = res_status;
      res_d.count_out      = CntOutW'(count_d);
    end
  end

  // holding slot drains into the output register
  assign xfer        = res_valid_q && (!out_valid_q || res_o.ready);
  assign res_valid_d = res_valid_q ? !xfer : res_set;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      res_valid_q <= res_valid_d;
      if (xfer) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    res_q <= res_d;
    if (xfer) begin
      out_q <= res_q;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.value_out      = out_q.value_out;
  assign res_o.found          = out_q.found;
  assign res_o.found_position = out_q.found_position;
  assign res_o.status         = out_q.status;
  assign res_o.count_out      = out_q.count_out;

endmodule

`default_nettype wire

// ===== rtl/ils_checker.sv =====
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks on the result channel of the indexed list store, bound
// to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_checker import ils_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [ValW-1:0]    value_out_i,
  input  logic               found_i,
  input  logic [PosW-1:0]    found_position_i,
  input  logic [StatusW-1:0] status_i,
  input  logic [CntOutW-1:0] count_out_i
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(value_out_i)
      && $stable(found_i) && $stable(found_position_i) && $stable(status_i)
      && $stable(count_out_i))
    else $error("result changed while stalled");

  // full status only when the count sits at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (status_i == ST_FULL) |-> count_out_i == CntOutW'(CAPACITY))
    else $error("full status with count below capacity");

  // a hit comes with ok status and no read word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && found_i |-> (status_i == ST_OK) && (value_out_i == '0))
    else $error("find hit with stray fields");

  // errors return no word and no hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (status_i != ST_OK) |-> (value_out_i == '0) && !found_i)
    else $error("error result with stray fields");

  // a hit lies inside the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && found_i |-> (CAPACITY > 256)
      || (CntOutW'(found_position_i) < count_out_i))
    else $error("find hit beyond element count");

endmodule

bind indexed_list_store_top ils_checker #(
  .CAPACITY (CAPACITY)
) u_ils_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .value_out_i      (res_o.value_out),
  .found_i          (res_o.found),
  .found_position_i (res_o.found_position),
  .status_i         (res_o.status),
  .count_out_i      (res_o.count_out)
);

`default_nettype wire

// ===== tb/ils_list_mirror_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_list_mirror_pkg
// Software copy of the indexed list store: applies each accepted request to
// its own list, queues the reply the block must give and checks the replies.
// ----------------------------------------------------------------------------

package ils_list_mirror_pkg;

  import ils_pkg::*;

  localparam int unsigned LIST_CAPACITY = 256;

  // codes outside the command set; the block must leave the list as it is and reply with ok status
  localparam logic [CmdW-1:0] CMD_RSVD_A = 3'd6;
  localparam logic [CmdW-1:0] CMD_RSVD_B = 3'd7;

  class list_mirror;
    logic [ValW-1:0] mirror_words [LIST_CAPACITY];
    int unsigned     mirror_count;
    res_t            awaited_replies [$];
    int unsigned     errors;
    int unsigned     replies_seen;
    int unsigned     cmd_tally [8];
    int unsigned     status_tally [4];
    int unsigned     find_hits;
    int unsigned     peak_count;

    function new();
      foreach (mirror_words[i]) mirror_words[i] = '0;
      mirror_count = 0;
      errors       = 0;
      replies_seen = 0;
      find_hits    = 0;
      peak_count   = 0;
      foreach (cmd_tally[i]) cmd_tally[i] = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function int unsigned size();
      return mirror_count;
    endfunction

    function logic [ValW-1:0] word_at(int unsigned idx);
      return mirror_words[idx];
    endfunction

    function int unsigned pending();
      return awaited_replies.size();
    endfunction

    // one accepted request: update the list and queue the reply it causes
    function void apply_command(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                                logic [ValW-1:0] word);
      res_t        r;
      int unsigned i;
      bit          hit;
      r        = '0;
      r.status = ST_OK;
      hit      = 1'b0;
      cmd_tally[cmd]++;
      case (cmd)
        CMD_APPEND: begin
          if (mirror_count >= LIST_CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            mirror_words[mirror_count] = word;
            mirror_count++;
          end
        end
        CMD_SET: begin
          if (pos >= mirror_count) r.status = ST_RANGE;
          else mirror_words[pos] = word;
        end
        CMD_GET: begin
          if (pos >= mirror_count) r.status = ST_RANGE;
          else r.value_out = mirror_words[pos];
        end
        CMD_REMOVE: begin
          if (pos >= mirror_count) begin
            r.status = ST_RANGE;
          end else begin
            r.value_out = mirror_words[pos];
            for (i = pos; i + 1 < mirror_count; i++) mirror_words[i] = mirror_words[i + 1];
            mirror_count--;
          end
        end
        CMD_FIND: begin
          for (i = 0; i < mirror_count; i++) begin
            if (!hit && mirror_words[i] == word) begin
              hit              = 1'b1;
              r.found          = 1'b1;
              r.found_position = PosW'(i);
            end
          end
          if (hit) find_hits++;
        end
        CMD_CLEAR: mirror_count = 0;
        default: ;
      endcase
      r.count_out = CntOutW'(mirror_count);
      status_tally[r.status]++;
      if (mirror_count > peak_count) peak_count = mirror_count;
      awaited_replies.push_back(r);
    endfunction

    task report_mismatch(string what, logic [ValW-1:0] got, logic [ValW-1:0] want);
      errors++;
      if (errors <= 40)
        $display("[%0t] reply %0d %s: got %0h, want %0h", $time, replies_seen, what, got,
                 want);
    endtask

    task check_reply(res_t got);
      res_t want;
      replies_seen++;
      if (awaited_replies.size() == 0) begin
        report_mismatch("reply with no request waiting", got.value_out, '0);
        return;
      end
      want = awaited_replies.pop_front();
      if (got.value_out !== want.value_out)
        report_mismatch("value_out", got.value_out, want.value_out);
      if (got.found !== want.found)
        report_mismatch("found", ValW'(got.found), ValW'(want.found));
      if (got.found_position !== want.found_position)
        report_mismatch("found_position", ValW'(got.found_position),
                        ValW'(want.found_position));
      if (got.status !== want.status)
        report_mismatch("status", ValW'(got.status), ValW'(want.status));
      if (got.count_out !== want.count_out)
        report_mismatch("count_out", ValW'(got.count_out), ValW'(want.count_out));
    endtask

    task check_leftovers();
      if (awaited_replies.size() != 0)
        report_mismatch("replies never returned", ValW'(awaited_replies.size()), '0);
    endtask
  endclass

endpackage

// ===== tb/indexed_list_store_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_top_tb
// Drives list commands into the indexed list store with random gaps on the
// request side and random stalls on the reply side, and checks every reply
// against a software copy of the list. A short directed run covers the edge
// cases, then random command sequences fill, search, edit and drain the list.
// ----------------------------------------------------------------------------

module indexed_list_store_top_tb;

  import ils_pkg::*;
  import ils_list_mirror_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1500;
  localparam int unsigned TAIL_CYCLES     = 2 * LIST_CAPACITY + 16;

  logic clk_i = 1'b0;
  logic rst_ni;

  ils_cmd_if cmd_if ();
  ils_res_if res_if ();

  indexed_list_store_top #(
    .CAPACITY   (LIST_CAPACITY),
    .DATA_WIDTH (ValW)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  list_mirror  list_ref;
  bit          calm;
  int unsigned issued;
  bit          filled;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    list_ref = new();
    rst_ni          = 1'b0;
    cmd_if.valid    = 1'b0;
    cmd_if.command  = '0;
    cmd_if.position = '0;
    cmd_if.value_in = '0;
    res_if.ready    = 1'b0;
  end

  // calm stretches have no idling on either side
  function automatic int unsigned draw_gap();
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [PosW-1:0] pick_pos();
    int unsigned n;
    n = list_ref.size();
    if (n > 0 && $urandom_range(0, 9) != 0) return PosW'($urandom_range(0, n - 1));
    return PosW'($urandom_range(0, 255));
  endfunction

  // small pool so that duplicates show up for find
  function automatic logic [ValW-1:0] pick_word();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 5) return ValW'($urandom_range(0, 15));
    if (k == 5) return ($urandom_range(0, 1) == 0) ? '0 : '1;
    return ValW'($urandom);
  endfunction

  // entered and left at a rising edge; valid stays high when the next
  // request follows with no gap
  task automatic send_request(input logic [CmdW-1:0] cmd, input logic [PosW-1:0] pos,
                              input logic [ValW-1:0] word);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= cmd;
    cmd_if.position <= pos;
    cmd_if.value_in <= word;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    list_ref.apply_command(cmd, pos, word);
    if (cmd <= CMD_CLEAR) issued++;
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (list_ref.pending() != 0);
  endtask

  task automatic send_find();
    logic [ValW-1:0] key;
    if (list_ref.size() > 0 && $urandom_range(0, 2) != 0)
      key = list_ref.word_at($urandom_range(0, list_ref.size() - 1));
    else
      key = pick_word();
    send_request(CMD_FIND, PosW'($urandom), key);
  endtask

  // reply side
  initial begin
    int unsigned gap;
    res_t        got;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      got.value_out      = res_if.value_out;
      got.found          = res_if.found;
      got.found_position = res_if.found_position;
      got.status         = res_if.status;
      got.count_out      = res_if.count_out;
      list_ref.check_reply(got);
    end
  end

  initial begin
    #10ms;
    $display("indexed_list_store_top_tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned kind;
    int unsigned len;
    int unsigned op;
    calm   = 1'b0;
    issued = 0;
    filled = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // empty list: every indexed access is out of range, find misses
    send_request(CMD_FIND,   8'd0,   32'd5);
    send_request(CMD_GET,    8'd0,   32'd0);
    send_request(CMD_REMOVE, 8'd0,   32'd0);
    send_request(CMD_SET,    8'd0,   32'hFFFF_FFFF);
    send_request(CMD_APPEND, 8'd255, 32'd0);
    send_request(CMD_APPEND, 8'd0,   32'hFFFF_FFFF);
    send_request(CMD_APPEND, 8'd0,   32'd5);
    send_request(CMD_APPEND, 8'd0,   32'hFFFF_FFFF);
    send_request(CMD_GET,    8'd1,   32'd0);
    send_request(CMD_SET,    8'd2,   32'hA5A5_A5A5);
    // duplicate key: first index wins
    send_request(CMD_FIND,   8'd255, 32'hFFFF_FFFF);
    send_request(CMD_FIND,   8'd0,   32'h1234_5678);
    send_request(CMD_GET,    8'd4,   32'd0);
    send_request(CMD_GET,    8'd255, 32'd0);
    send_request(CMD_REMOVE, 8'd3,   32'd0);
    send_request(CMD_REMOVE, 8'd0,   32'd0);
    send_request(CMD_GET,    8'd0,   32'd0);
    send_request(CMD_RSVD_A, 8'd255, 32'hFFFF_FFFF);
    send_request(CMD_RSVD_B, 8'd0,   32'd0);
    send_request(CMD_CLEAR,  8'd255, 32'hFFFF_FFFF);
    send_request(CMD_GET,    8'd0,   32'd0);
    send_request(CMD_APPEND, 8'd0,   32'd1);
    send_request(CMD_FIND,   8'd0,   32'd1);
    wait_drained();

    issued = 0;
    while (issued < RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 99);
      if (!filled && issued > 600) kind = 20;
      calm = ($urandom_range(0, 3) == 0);
      if (kind < 20) begin
        len = $urandom_range(1, 24);
        repeat (len) send_request(CMD_APPEND, PosW'($urandom), pick_word());
      end else if (kind < 22) begin
        // fill to capacity, then push against the full store
        filled = 1'b1;
        while (list_ref.size() < LIST_CAPACITY)
          send_request(CMD_APPEND, PosW'($urandom), pick_word());
        repeat ($urandom_range(1, 3)) send_request(CMD_APPEND, PosW'($urandom), pick_word());
      end else if (kind < 65) begin
        len = $urandom_range(4, 20);
        repeat (len) begin
          op = $urandom_range(0, 9);
          case (op)
            0, 1:    send_request(CMD_SET, pick_pos(), pick_word());
            2, 3:    send_request(CMD_GET, pick_pos(), ValW'($urandom));
            4, 5:    send_request(CMD_REMOVE, pick_pos(), ValW'($urandom));
            6, 7:    send_find();
            default: send_request(CMD_APPEND, PosW'($urandom), pick_word());
          endcase
        end
      end else if (kind < 75) begin
        len = $urandom_range(1, 20);
        repeat (len) send_request(CMD_REMOVE, pick_pos(), ValW'($urandom));
      end else if (kind < 80) begin
        send_request(CMD_CLEAR, PosW'($urandom), ValW'($urandom));
      end else begin
        len = $urandom_range(1, 8);
        repeat (len)
          send_request(CmdW'($urandom_range(0, 7)), PosW'($urandom), ValW'($urandom));
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    calm = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    list_ref.check_leftovers();

    $display("requests: %0d append, %0d set, %0d get, %0d remove, %0d find, %0d clear, %0d other",
             list_ref.cmd_tally[CMD_APPEND], list_ref.cmd_tally[CMD_SET],
             list_ref.cmd_tally[CMD_GET], list_ref.cmd_tally[CMD_REMOVE],
             list_ref.cmd_tally[CMD_FIND], list_ref.cmd_tally[CMD_CLEAR],
             list_ref.cmd_tally[CMD_RSVD_A] + list_ref.cmd_tally[CMD_RSVD_B]);
    $display("replies checked: %0d, out of range %0d, store full %0d, find hits %0d, peak %0d",
             list_ref.replies_seen, list_ref.status_tally[ST_RANGE],
             list_ref.status_tally[ST_FULL], list_ref.find_hits, list_ref.peak_count);
    if (list_ref.errors == 0) begin
      $display("indexed_list_store_top_tb: done, clean");
    end else begin
      $display("indexed_list_store_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ils_pkg.sv
rtl/ils_if.sv
rtl/ils_store.sv
rtl/indexed_list_store_top.sv
rtl/ils_checker.sv
tb/ils_list_mirror_pkg.sv
tb/indexed_list_store_top_tb.sv
